@@ design/mdpt_pkg.sv @@
`default_nettype none

package mdpt_pkg;

  // Default sizing of the store and coordinates
  localparam int MaxPointsDef  = 64;
  localparam int CoordBitsDef  = 24;

  // Fixed field widths
  localparam int DistW         = 52;  // squared threshold register
  localparam int KeptCountW    = 7;   // kept_count result field
  localparam int SqW           = 64;  // saturating squared-distance accumulator
  localparam int MagMaxW       = 33;  // widest |difference| over the coordinate range

  // Result flags carried in tuser
  typedef struct packed {
    logic dropped_full;
    logic accepted;
  } result_flags_t;

endpackage

`default_nettype wire

@@ design/min_distance_point_thinning.sv @@
`default_nettype none
// Per input word: for each point held in the current set after the optional clear, the
//   sequencer runs StChk, StDiff, StSq (three passes) and StCmp, with an early exit on the
//   first point too close, then StFin. A new word is taken only in StIdle; StFin waits while
//   the previous result word is not taken. The single multiplier squares x, y and z.
// Reset: point count, threshold and output valid cleared; point store not cleared.

module min_distance_point_thinning
  import mdpt_pkg::*;
#(
  parameter int MAX_POINTS = MaxPointsDef,
  parameter int COORD_BITS = CoordBitsDef,
  localparam int TDATA_W   = ((3 * COORD_BITS + 7) / 8) * 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,

  // configuration: min_dist_squared
  input  wire logic               cfg_we_i,
  input  wire logic [DistW-1:0]   cfg_wdata_i,

  // input points
  input  wire logic               s_axis_tvalid,
  output      logic               s_axis_tready,
  input  wire logic [TDATA_W-1:0] s_axis_tdata,  // point_x, point_y, point_z, zero pad
  input  wire logic               s_axis_tuser,  // first_of_set

  // results
  output      logic               m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output      logic [7:0]         m_axis_tdata,  // kept_count, zero pad
  output      logic [1:0]         m_axis_tuser   // accepted, dropped_full
);

  // ---------------------------------------------------------------------------
  // Sizing
  // ---------------------------------------------------------------------------
  localparam int AddrW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CountW = $clog2(MAX_POINTS + 1);
  localparam int MagW   = COORD_BITS + 1;      // |a - b| fits unsigned here
  localparam int PointW = 3 * COORD_BITS;

  // Sequencer states
  localparam logic [2:0] StIdle = 3'd0;  // waiting for a point
  localparam logic [2:0] StChk  = 3'd1;  // end of store? else issue read
  localparam logic [2:0] StDiff = 3'd2;  // stored point arrives, form |dx|,|dy|,|dz|
  localparam logic [2:0] StSq   = 3'd3;  // three passes through the multiplier
  localparam logic [2:0] StCmp  = 3'd4;  // distance against threshold
  localparam logic [2:0] StFin  = 3'd5;  // append / flag, load output register

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  logic [2:0]             state_q, state_d;
  logic [CountW-1:0]      count_q, count_d;     // points in current set
  logic [CountW-1:0]      idx_q, idx_d;         // stored point under test
  logic [DistW-1:0]       thr_q;
  logic [1:0]             phase_q, phase_d;     // which axis in the multiplier
  logic                   far_q, far_d;
  logic [COORD_BITS-1:0]  px_q, py_q, pz_q;
  logic [MagW-1:0]        mag_q [3];
  logic [SqW-1:0]         acc_q, acc_d;
  logic                   out_valid_q, out_valid_d;
  result_flags_t          out_flags_q, out_flags_d;
  logic [KeptCountW-1:0]  out_count_q, out_count_d;

  // ---------------------------------------------------------------------------
  // Point store
  // ---------------------------------------------------------------------------
  logic              ram_we, ram_re;
  logic [PointW-1:0] ram_rdata;

  mdpt_ram #(
    .Width (PointW),
    .Depth (MAX_POINTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[AddrW-1:0]),
    .wdata_i ({pz_q, py_q, px_q}),
    .re_i    (ram_re),
    .raddr_i (idx_q[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Difference magnitudes against the stored point (three independent subtracts)
  // ---------------------------------------------------------------------------
  logic [COORD_BITS-1:0] sx, sy, sz;
  logic [MagW-1:0]       dx, dy, dz;
  logic [MagW-1:0]       mx, my, mz;

  assign sx = ram_rdata[COORD_BITS-1:0];
  assign sy = ram_rdata[2*COORD_BITS-1:COORD_BITS];
  assign sz = ram_rdata[3*COORD_BITS-1:2*COORD_BITS];

  assign dx = {px_q[COORD_BITS-1], px_q} - {sx[COORD_BITS-1], sx};
  assign dy = {py_q[COORD_BITS-1], py_q} - {sy[COORD_BITS-1], sy};
  assign dz = {pz_q[COORD_BITS-1], pz_q} - {sz[COORD_BITS-1], sz};

  assign mx = dx[MagW-1] ? (~dx + MagW'(1)) : dx;
  assign my = dy[MagW-1] ? (~dy + MagW'(1)) : dy;
  assign mz = dz[MagW-1] ? (~dz + MagW'(1)) : dz;

  // ---------------------------------------------------------------------------
  // Shared square-and-accumulate unit
  // Square saturates once |d| passes 32 bits, the sum saturates at 64 bits.
  // ---------------------------------------------------------------------------
  logic [MagW-1:0]    mul_in;
  logic [MagMaxW-1:0] mul_ext;
  logic [2*MagMaxW-1:0] prod;
  logic [SqW-1:0]     sq;
  logic [SqW:0]       sum;
  logic [SqW-1:0]     acc_next;

  always_comb begin
    unique case (phase_q)
      2'd0:    mul_in = mag_q[0];
      2'd1:    mul_in = mag_q[1];
      2'd2:    mul_in = mag_q[2];
      default: mul_in = '0;
    endcase
  end

  assign mul_ext  = MagMaxW'(mul_in);
  assign prod     = (2*MagMaxW)'(mul_ext) * (2*MagMaxW)'(mul_ext);
  assign sq       = mul_ext[MagMaxW-1] ? '1 : prod[SqW-1:0];
  assign sum      = {1'b0, acc_q} + {1'b0, sq};
  assign acc_next = sum[SqW] ? '1 : sum[SqW-1:0];

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  logic in_fire, out_free;

  assign s_axis_tready = (state_q == StIdle);
  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign out_free      = ~out_valid_q | m_axis_tready;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    phase_d     = phase_q;
    far_d       = far_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q & ~m_axis_tready;
    out_flags_d = out_flags_q;
    out_count_d = out_count_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          if (s_axis_tuser) begin
            count_d = '0;  // new set
          end
          idx_d   = '0;
          far_d   = 1'b1;
          state_d = StChk;
        end
      end
      StChk: begin
        if (idx_q == count_q) begin
          state_d = StFin;  // far from every stored point
        end else begin
          ram_re  = 1'b1;
          state_d = StDiff;
        end
      end
      StDiff: begin
        acc_d   = '0;
        phase_d = 2'd0;
        state_d = StSq;
      end
      StSq: begin
        acc_d   = acc_next;
        phase_d = phase_q + 2'd1;
        if (phase_q == 2'd2) begin
          state_d = StCmp;
        end
      end
      StCmp: begin
        if (acc_q < SqW'(thr_q)) begin
          far_d   = 1'b0;  // too close, stop scanning
          state_d = StFin;
        end else begin
          idx_d   = idx_q + CountW'(1);
          state_d = StChk;
        end
      end
      StFin: begin
        if (out_free) begin
          out_flags_d = '0;
          if (far_q) begin
            if (count_q < CountW'(MAX_POINTS)) begin
              ram_we                   = 1'b1;
              count_d                  = count_q + CountW'(1);
              out_flags_d.accepted     = 1'b1;
            end else begin
              out_flags_d.dropped_full = 1'b1;
            end
          end
          out_count_d = KeptCountW'(count_d);
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      thr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    phase_q     <= phase_d;
    far_q       <= far_d;
    acc_q       <= acc_d;
    out_flags_q <= out_flags_d;
    out_count_q <= out_count_d;
    if (in_fire) begin
      px_q <= s_axis_tdata[COORD_BITS-1:0];
      py_q <= s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
      pz_q <= s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];
    end
    if (state_q == StDiff) begin
      mag_q[0] <= mx;
      mag_q[1] <= my;
      mag_q[2] <= mz;
    end
  end

  // ---------------------------------------------------------------------------
  // Result word
  // ---------------------------------------------------------------------------
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_count_q};
  assign m_axis_tuser  = out_flags_q;

endmodule

`default_nettype wire

@@ design/mdpt_ram.sv @@
`default_nettype none

module mdpt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output      logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import mdpt_pkg::*;

  localparam int MAX_PTS = MaxPointsDef;
  localparam int CW      = CoordBitsDef;
  localparam int TDW     = ((3 * CW + 7) / 8) * 8;

  // The watchdog limit covers the worst item, a scan of a full store, plus the long hold.
  localparam int WATCHDOG_LIMIT   = 5000;
  localparam int LONG_HOLD_CYCLES = 600;
  localparam int DRAIN_TAIL       = 3 + 6 * MAX_PTS + 20;

  localparam logic [DistW-1:0] THRESH_MAX = '1;
  localparam logic [CW-1:0]    COORD_MAX  = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0]    COORD_MIN  = {1'b1, {(CW-1){1'b0}}};

  typedef struct packed {
    result_flags_t               flags;
    logic [KeptCountW-1:0]       kept;
  } verdict_t;

  // Greedy thinning predictor plus FIFO of pending verdicts.
  class thinning_scoreboard;
    logic signed [CW-1:0] kx [MAX_PTS];
    logic signed [CW-1:0] ky [MAX_PTS];
    logic signed [CW-1:0] kz [MAX_PTS];
    int                   held;
    logic [DistW-1:0]     thresh;
    verdict_t             verdict_q[$];
    int                   mismatches;

    function new();
      held       = 0;
      thresh     = '0;
      mismatches = 0;
    endfunction

    function void set_threshold(logic [DistW-1:0] v);
      thresh = v;
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction

    // |a-b|^2; the difference never reaches -2^CW, so the 25-bit negate is safe.
    function logic [63:0] axis_sq(logic signed [CW-1:0] a, logic signed [CW-1:0] b);
      logic signed [CW:0] d;
      logic [63:0]        m;
      d = a - b;
      m = d[CW] ? 64'(-d) : 64'(d);
      return m * m;
    endfunction

    function void note_point(logic first, logic [CW-1:0] x, logic [CW-1:0] y,
                             logic [CW-1:0] z);
      verdict_t    v;
      bit          far;
      logic [63:0] dsq;
      if (first) held = 0;
      far = 1'b1;
      for (int i = 0; i < held; i++) begin
        dsq = axis_sq(x, kx[i]) + axis_sq(y, ky[i]) + axis_sq(z, kz[i]);
        if (dsq < 64'(thresh)) begin
          far = 1'b0;
          break;
        end
      end
      v = '0;
      if (far) begin
        if (held < MAX_PTS) begin
          kx[held] = x;
          ky[held] = y;
          kz[held] = z;
          held++;
          v.flags.accepted = 1'b1;
        end else begin
          v.flags.dropped_full = 1'b1;
        end
      end
      v.kept = KeptCountW'(held);
      verdict_q.push_back(v);
    endfunction

    function void flag_mismatch(string msg);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] mismatch: %s", $time, msg);
    endfunction

    function void check_verdict(result_flags_t flags, logic [KeptCountW-1:0] kept);
      verdict_t want;
      if (verdict_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected word: accepted=%b dropped_full=%b kept_count=%0d",
                                flags.accepted, flags.dropped_full, kept));
        return;
      end
      want = verdict_q.pop_front();
      if (flags.accepted !== want.flags.accepted ||
          flags.dropped_full !== want.flags.dropped_full || kept !== want.kept)
        flag_mismatch($sformatf(
          "exp accepted=%b dropped_full=%b kept_count=%0d, got %b %b %0d",
          want.flags.accepted, want.flags.dropped_full, want.kept,
          flags.accepted, flags.dropped_full, kept));
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [DistW-1:0]    cfg_wdata_i   = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [TDW-1:0]      s_axis_tdata  = '0;  // point_x, point_y, point_z, zero pad
  logic                s_axis_tuser  = 1'b0; // first_of_set
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [7:0]          m_axis_tdata;         // kept_count, zero pad
  logic [1:0]          m_axis_tuser;         // accepted, dropped_full

  thinning_scoreboard sb;

  int burst_left     = 0;
  bit sender_steady  = 1'b0;
  bit long_hold_req  = 1'b0;
  int long_hold_left = 0;
  int rx_mode        = 0;
  int rx_mode_left   = 0;
  int rx_stall_left  = 0;
  int rx_tick        = 0;
  int idle_cycles    = 0;
  bit activity;

  min_distance_point_thinning i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Handshakes are sampled with pre-edge values; watchdog counts silent cycles.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      activity = 1'b0;
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_verdict(result_flags_t'(m_axis_tuser), m_axis_tdata[KeptCountW-1:0]);
        activity = 1'b1;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_point(s_axis_tuser, s_axis_tdata[CW-1:0], s_axis_tdata[2*CW-1:CW],
                      s_axis_tdata[3*CW-1:2*CW]);
        activity = 1'b1;
      end
      if (cfg_we_i) activity = 1'b1;
      idle_cycles = activity ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] watchdog: no word moved for %0d cycles", $time, idle_cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Result side back-pressure: a one-shot long hold on request, otherwise rotating modes.
  always @(posedge clk_i) begin
    rx_tick++;
    if (long_hold_left > 0) begin
      m_axis_tready <= 1'b0;
      long_hold_left--;
    end else if (long_hold_req) begin
      long_hold_req  = 1'b0;
      long_hold_left = LONG_HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = $urandom_range(0, 3);
        rx_mode_left = $urandom_range(20, 300);
      end
      rx_mode_left--;
      case (rx_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        2: m_axis_tready <= (rx_tick % 4 == 0);
        default: begin
          if (rx_stall_left > 0) begin
            rx_stall_left--;
            m_axis_tready <= 1'b0;
          end else begin
            if ($urandom_range(0, 7) == 0) rx_stall_left = $urandom_range(1, 30);
            m_axis_tready <= 1'b1;
          end
        end
      endcase
    end
  end

  // Present one point and hold it until the word is taken; bursts, with random gaps between unless steady.
  task automatic offer_point(logic first, logic [CW-1:0] x, logic [CW-1:0] y,
                             logic [CW-1:0] z);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (!sender_steady && $urandom_range(0, 3) != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= TDW'({z, y, x});
    s_axis_tuser  <= first;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
  endtask

  // Sender pauses until every pending verdict has come back.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [DistW-1:0] v);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_threshold(v);
  endtask

  function automatic logic [CW-1:0] pick_coord(logic [CW-1:0] center, int spread_log);
    logic [CW-1:0] off;
    off = CW'($urandom_range(0, 32'(1) << spread_log));
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return COORD_MAX;
          1: return COORD_MIN;
          2: return '0;
          default: return '1;
        endcase
      end
      1, 2: return CW'($urandom);
      default: return $urandom_range(0, 1) ? center + off : center - off;
    endcase
  endfunction

  // One set: clustered points around a random center, with exact repeats mixed in.
  task automatic play_set(int len, int spread_log, int dup_pct);
    logic [CW-1:0] cx, cy, cz, px, py, pz;
    logic [CW-1:0] hx[$], hy[$], hz[$];
    int            pick;
    cx = CW'($urandom);
    cy = CW'($urandom);
    cz = CW'($urandom);
    for (int k = 0; k < len; k++) begin
      if (hx.size() > 0 && $urandom_range(0, 99) < dup_pct) begin
        pick = $urandom_range(0, hx.size() - 1);
        px = hx[pick];
        py = hy[pick];
        pz = hz[pick];
      end else begin
        px = pick_coord(cx, spread_log);
        py = pick_coord(cy, spread_log);
        pz = pick_coord(cz, spread_log);
      end
      hx.push_back(px);
      hy.push_back(py);
      hz.push_back(pz);
      offer_point(k == 0, px, py, pz);
    end
  endtask

  task automatic run_phase(logic [DistW-1:0] thr, int n_items, bit steady);
    int sent;
    int len;
    int roll;
    write_threshold(thr);
    sender_steady = steady;
    sent = 0;
    while (sent < n_items) begin
      roll = $urandom_range(0, 99);
      if (roll < 80)      len = $urandom_range(1, 12);
      else if (roll < 95) len = $urandom_range(13, 40);
      else                len = $urandom_range(65, 80);
      play_set(len, $urandom_range(0, 20), $urandom_range(0, 15));
      sent += len;
    end
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset threshold is zero: empty store, repeated point, coordinate extremes.
    offer_point(1'b1, '0, '0, '0);
    offer_point(1'b0, '0, '0, '0);
    offer_point(1'b0, COORD_MAX, COORD_MAX, COORD_MAX);
    offer_point(1'b0, COORD_MIN, COORD_MIN, COORD_MIN);
    offer_point(1'b0, COORD_MIN, COORD_MAX, '1);
    offer_point(1'b0, CW'(1), '1, COORD_MAX);

    // Spacing of 10 LSB: distance exactly at threshold passes, just inside fails.
    write_threshold(DistW'(100));
    offer_point(1'b1, '0, '0, '0);
    offer_point(1'b0, CW'(10), '0, '0);
    offer_point(1'b0, '0, CW'(9), '0);
    offer_point(1'b0, CW'(5), -CW'(6), CW'(7));
    offer_point(1'b0, CW'(10), '0, '0);

    // Largest threshold: nothing passes except into an empty store.
    write_threshold(THRESH_MAX);
    offer_point(1'b1, COORD_MAX, COORD_MAX, COORD_MAX);
    offer_point(1'b0, COORD_MIN, COORD_MIN, COORD_MIN);
    offer_point(1'b1, COORD_MIN, '0, COORD_MAX);

    // Full store with zero threshold: everything past 64 is dropped.
    write_threshold('0);
    play_set(72, 20, 0);
    // Full store with threshold 1: repeats are too close, new points are dropped.
    write_threshold(DistW'(1));
    play_set(90, 20, 15);

    run_phase('0, 120, 1'b0);
    long_hold_req = 1'b1;
    run_phase(DistW'($urandom_range(2, 65536)), 200, 1'b0);
    run_phase(THRESH_MAX, 100, 1'b0);
    run_phase(DistW'({$urandom, $urandom}) >> $urandom_range(12, 36), 250, 1'b0);
    run_phase(DistW'({$urandom, $urandom}), 100, 1'b0);
    run_phase(DistW'({$urandom, $urandom}) >> $urandom_range(12, 36), 350, 1'b1);
    run_phase('0, 100, 1'b0);

    wait_drained();
    repeat (DRAIN_TAIL) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/mdpt_pkg.sv
design/mdpt_ram.sv
design/min_distance_point_thinning.sv
dv/tb_top.sv
